### rtl/mld_pkg.sv
// ----------------------------------------------------------------------------
// mld_pkg
// Shared types and constants for the marker/length deframer.
// ----------------------------------------------------------------------------
package mld_pkg;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_MARK    = 2'd1,
        PH_LOW     = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef enum logic {
        KIND_TEXT    = 1'b0,
        KIND_PAYLOAD = 1'b1
    } t_kind;

    // One classified input byte: up to three results of the same kind.
    typedef struct packed {
        logic [1:0] cnt;        // number of results, 1 to 3
        t_kind      kind;
        logic       frame_end;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_rec;

    localparam logic [0:0]  REG_MARKER_BYTE   = 1'b0;
    localparam logic [0:0]  REG_MAX_PAYLOAD   = 1'b1;
    localparam logic [7:0]  MARKER_RESET      = 8'd62;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd255;

endpackage

### rtl/marker_length_deframer_core.sv
// Path: an accepted byte's record is written into the queue, then loaded
//   into the result register when that register is empty or being popped.
// Throughput: one byte per cycle while full is low; a rejected header yields
//   up to three text results, drained one per cycle by the result register
//   while the receiver pops, from a QUEUE_DEPTH-record queue, so full rises
//   only under sustained rejects or a stalled receiver. Reset: synchronous,
//   active low; clears phase, counts, queue, config and output-valid flag.
// ----------------------------------------------------------------------------
// marker_length_deframer_core
// Byte-serial deframer for marker / 16-bit LE length / payload frames.
// ----------------------------------------------------------------------------
module marker_length_deframer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    // results
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    output logic        o_last,
    output logic [31:0] o_frames_total,
    output logic [31:0] o_dropped_total
);

    logic [7:0]    r_marker_byte;
    logic [15:0]   r_max_payload;
    logic          accept;
    logic          rec_wr;
    mld_pkg::t_rec rec_wr_data;
    logic          rec_valid;
    mld_pkg::t_rec rec_rd_data;
    logic          rec_pop;

    assign pready = 1'b1;
    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_byte <= mld_pkg::MARKER_RESET;
            r_max_payload <= mld_pkg::MAX_PAYLOAD_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                mld_pkg::REG_MARKER_BYTE: r_marker_byte <= pwdata[7:0];
                mld_pkg::REG_MAX_PAYLOAD: r_max_payload <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mld_pkg::REG_MARKER_BYTE: prdata = {24'd0, r_marker_byte};
            mld_pkg::REG_MAX_PAYLOAD: prdata = {16'd0, r_max_payload};
            default:                  prdata = '0;
        endcase
    end

    mld_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_marker_byte (r_marker_byte),
        .i_max_payload (r_max_payload),
        .i_accept      (accept),
        .i_in_byte     (i_in_byte),
        .o_rec_valid   (rec_wr),
        .o_rec         (rec_wr_data)
    );

    mld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (rec_wr),
        .i_wr_data  (rec_wr_data),
        .o_full     (full),
        .o_rd_valid (rec_valid),
        .o_rd_data  (rec_rd_data),
        .i_rd       (rec_pop)
    );

    mld_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rec_valid     (rec_valid),
        .i_rec           (rec_rd_data),
        .o_rec_pop       (rec_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_kind          (o_kind),
        .o_out_byte      (o_out_byte),
        .o_frame_end     (o_frame_end),
        .o_last          (o_last),
        .o_frames_total  (o_frames_total),
        .o_dropped_total (o_dropped_total)
    );

endmodule

### rtl/mld_front.sv
// ----------------------------------------------------------------------------
// mld_front
// Header parser: tracks frame phase and turns each accepted byte into a
// record of zero to three results.
// ----------------------------------------------------------------------------
module mld_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_marker_byte,
    input  logic [15:0]    i_max_payload,
    input  logic           i_accept,
    input  logic [7:0]     i_in_byte,
    output logic           o_rec_valid,
    output mld_pkg::t_rec  o_rec
);

    mld_pkg::t_phase r_phase, n_phase;
    logic [7:0]      r_lo, n_lo;
    logic [15:0]     r_left, n_left;
    logic [15:0]     len;

    assign len = {i_in_byte, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mld_pkg::PH_HUNT;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
        r_lo <= n_lo;
    end

    always_comb begin
        n_phase     = r_phase;
        n_lo        = r_lo;
        n_left      = r_left;
        o_rec_valid = 1'b0;
        o_rec       = '0;
        if (i_accept) begin
            case (r_phase)
                mld_pkg::PH_PAYLOAD: begin
                    o_rec_valid     = 1'b1;
                    o_rec.cnt       = 2'd1;
                    o_rec.kind      = mld_pkg::KIND_PAYLOAD;
                    o_rec.b0        = i_in_byte;
                    o_rec.frame_end = (r_left <= 16'd1);
                    if (r_left <= 16'd1) begin
                        n_phase = mld_pkg::PH_HUNT;
                        n_left  = '0;
                    end else begin
                        n_left = r_left - 16'd1;
                    end
                end
                mld_pkg::PH_LOW: begin
                    if (len == 16'd0 || len > i_max_payload) begin
                        // drop the marker, rescan both held bytes
                        o_rec_valid = 1'b1;
                        o_rec.kind  = mld_pkg::KIND_TEXT;
                        o_rec.b0    = i_marker_byte;
                        if (r_lo == i_marker_byte) begin
                            o_rec.cnt = 2'd1;
                            n_lo      = i_in_byte;
                            n_phase   = mld_pkg::PH_LOW;
                        end else begin
                            o_rec.b1 = r_lo;
                            if (i_in_byte == i_marker_byte) begin
                                o_rec.cnt = 2'd2;
                                n_phase   = mld_pkg::PH_MARK;
                            end else begin
                                o_rec.cnt = 2'd3;
                                o_rec.b2  = i_in_byte;
                                n_phase   = mld_pkg::PH_HUNT;
                            end
                        end
                    end else begin
                        n_left  = len;
                        n_phase = mld_pkg::PH_PAYLOAD;
                    end
                end
                mld_pkg::PH_MARK: begin
                    n_lo    = i_in_byte;
                    n_phase = mld_pkg::PH_LOW;
                end
                mld_pkg::PH_HUNT: begin
                    if (i_in_byte == i_marker_byte) begin
                        n_phase = mld_pkg::PH_MARK;
                    end else begin
                        o_rec_valid = 1'b1;
                        o_rec.cnt   = 2'd1;
                        o_rec.kind  = mld_pkg::KIND_TEXT;
                        o_rec.b0    = i_in_byte;
                    end
                end
                default: begin
                    n_phase = mld_pkg::PH_HUNT;
                end
            endcase
        end
    end

endmodule

### rtl/mld_queue.sv
// ----------------------------------------------------------------------------
// mld_queue
// Small record queue between the parser and the result stage.
// ----------------------------------------------------------------------------
module mld_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  mld_pkg::t_rec  i_wr_data,
    output logic           o_full,
    output logic           o_rd_valid,
    output mld_pkg::t_rec  o_rd_data,
    input  logic           i_rd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mld_pkg::t_rec r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          wr_en, rd_en;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_en      = i_wr && !o_full;
    assign rd_en      = i_rd && o_rd_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

### rtl/mld_back.sv
// ----------------------------------------------------------------------------
// mld_back
// Result stage: expands each record into single results, keeps the running
// frame and dropped-byte counts, and holds the output register.
// ----------------------------------------------------------------------------
module mld_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_rec_valid,
    input  mld_pkg::t_rec  i_rec,
    output logic           o_rec_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_kind,
    output logic [7:0]     o_out_byte,
    output logic           o_frame_end,
    output logic           o_last,
    output logic [31:0]    o_frames_total,
    output logic [31:0]    o_dropped_total
);

    logic        r_out_valid;
    logic [1:0]  r_idx;
    logic [31:0] r_frames, r_dropped;
    logic [31:0] n_frames, n_dropped;
    logic        load, is_last;
    logic [7:0]  sel_byte;

    assign o_empty   = !r_out_valid;
    assign load      = i_rec_valid && (!r_out_valid || i_pop);
    assign is_last   = (r_idx == i_rec.cnt - 2'd1);
    assign o_rec_pop = load && is_last;

    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_rec.b0;
            2'd1:    sel_byte = i_rec.b1;
            default: sel_byte = i_rec.b2;
        endcase
        n_frames  = r_frames;
        n_dropped = r_dropped;
        if (i_rec.kind == mld_pkg::KIND_TEXT) begin
            n_dropped = r_dropped + 32'd1;
        end else if (i_rec.frame_end) begin
            n_frames = r_frames + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_frames    <= '0;
            r_dropped   <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? 2'd0 : r_idx + 2'd1;
                r_frames    <= n_frames;
                r_dropped   <= n_dropped;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            o_kind          <= i_rec.kind;
            o_out_byte      <= sel_byte;
            o_frame_end     <= i_rec.frame_end;
            o_last          <= is_last;
            o_frames_total  <= n_frames;
            o_dropped_total <= n_dropped;
        end
    end

endmodule
